// File: rtl/core/iedq_pkg.sv
// Shared constants and result codes for the immediate and delayed event queue.
package iedq_pkg;

   localparam int FIFO_DEPTH_DEF  = 16;
   localparam int TIMED_DEPTH_DEF = 16;
   localparam int WORD_BITS_DEF   = 32;
   localparam int TIME_BITS_DEF   = 48;
   localparam int DELAY_BITS      = 32;
   localparam int STATUS_BITS     = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_DELIVERED = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOTHING   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_ACCEPTED  = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd3;

endpackage

// File: rtl/core/immediate_and_delayed_event_queue.sv
// Top level of the event queue: command decode, FIFO pointers and sorted timed insert.
// A beat is taken when start is high and busy is low, and its single result appears on
// the rsp_ ports for one cycle with rsp_valid high; the receiver cannot stall it. An
// immediate push, a rejected push and a pop with both stores empty answer in the cycle
// after acceptance; any other pop first reads its store in S_FRD or S_TRD. A timed push
// into an empty store also answers in the cycle after acceptance. Otherwise it walks the
// timed memory from its tail, moving one later entry per cycle, so that every stored
// entry whose release time is later than the new one moves up one place. Both stores are
// circular buffers in synchronous memories.
module immediate_and_delayed_event_queue #(
   parameter int FIFO_DEPTH  = iedq_pkg::FIFO_DEPTH_DEF,
   parameter int TIMED_DEPTH = iedq_pkg::TIMED_DEPTH_DEF,
   parameter int WORD_BITS   = iedq_pkg::WORD_BITS_DEF,
   parameter int TIME_BITS   = iedq_pkg::TIME_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_op,
   input  logic [TIME_BITS-1:0]             req_now_ms,
   input  logic [iedq_pkg::DELAY_BITS-1:0]  req_delay_ms,
   input  logic [WORD_BITS-1:0]             req_payload,
   output logic                             rsp_valid,
   output logic [iedq_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [WORD_BITS-1:0]             rsp_event_out,
   output logic                             rsp_from_timed
);

   localparam int FAW = $clog2(FIFO_DEPTH);
   localparam int FCW = $clog2(FIFO_DEPTH + 1);
   localparam int TAW = $clog2(TIMED_DEPTH);
   localparam int TCW = $clog2(TIMED_DEPTH + 1);
   localparam int EW  = TIME_BITS + WORD_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FRD  = 3'd1;
   localparam logic [2:0] S_TRD  = 3'd2;
   localparam logic [2:0] S_INS  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   localparam logic [FAW-1:0] F_LAST = FAW'(FIFO_DEPTH - 1);
   localparam logic [TAW-1:0] T_LAST = TAW'(TIMED_DEPTH - 1);
   localparam logic [FCW-1:0] F_FULL = FCW'(FIFO_DEPTH);
   localparam logic [TCW-1:0] T_FULL = TCW'(TIMED_DEPTH);
   localparam logic [TAW:0]   T_SPAN = (TAW + 1)'(TIMED_DEPTH);

   function automatic logic [TAW-1:0] tidx(input logic [TAW-1:0] h, input logic [TAW-1:0] off);
      logic [TAW:0] sum;
      sum = {1'b0, h} + {1'b0, off};
      if (sum >= T_SPAN) begin
         sum = sum - T_SPAN;
      end
      return sum[TAW-1:0];
   endfunction

   logic [2:0]                        state_ff, state_in;
   logic [FAW-1:0]                    fhead_ff, fhead_in, ftail_ff, ftail_in;
   logic [FCW-1:0]                    fcount_ff, fcount_in;
   logic [TAW-1:0]                    thead_ff, thead_in;
   logic [TCW-1:0]                    tcount_ff, tcount_in;
   logic [TCW-1:0]                    pos_ff, pos_in;
   logic [TIME_BITS-1:0]              now_ff, now_in, rel_ff, rel_in;
   logic [WORD_BITS-1:0]              word_ff, word_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [iedq_pkg::STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic [WORD_BITS-1:0]              rsp_event_ff, rsp_event_in;
   logic                              rsp_timed_ff, rsp_timed_in;

   logic                              accept;
   logic [TIME_BITS:0]                rel_sum;
   logic [TIME_BITS-1:0]              rel_sat;
   logic                              f_we, f_re;
   logic [WORD_BITS-1:0]              f_rdata;
   logic                              t_we, t_re;
   logic [TAW-1:0]                    t_waddr, t_raddr;
   logic [EW-1:0]                     t_wdata, t_rdata;
   logic [TIME_BITS-1:0]              t_rrel;
   logic [TCW-1:0]                    off_a, off_b;

   assign accept  = start && (state_ff == S_IDLE);
   assign busy    = (state_ff != S_IDLE);
   assign rel_sum = {1'b0, req_now_ms} + (TIME_BITS + 1)'(req_delay_ms);
   assign rel_sat = rel_sum[TIME_BITS] ? '1 : rel_sum[TIME_BITS-1:0];
   assign t_rrel  = t_rdata[EW-1:WORD_BITS];

   always_comb begin
      state_in      = state_ff;
      fhead_in      = fhead_ff;
      ftail_in      = ftail_ff;
      fcount_in     = fcount_ff;
      thead_in      = thead_ff;
      tcount_in     = tcount_ff;
      pos_in        = pos_ff;
      now_in        = now_ff;
      rel_in        = rel_ff;
      word_in       = word_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_event_in  = rsp_event_ff;
      rsp_timed_in  = rsp_timed_ff;
      f_we          = 1'b0;
      f_re          = 1'b0;
      t_we          = 1'b0;
      t_re          = 1'b0;
      t_waddr       = tidx(thead_ff, pos_ff[TAW-1:0]);
      t_wdata       = {rel_ff, word_ff};
      off_a         = tcount_ff - TCW'(1);
      off_b         = pos_ff - TCW'(2);
      t_raddr       = tidx(thead_ff, off_a[TAW-1:0]);
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               now_in       = req_now_ms;
               rel_in       = rel_sat;
               word_in      = req_payload;
               rsp_event_in = '0;
               rsp_timed_in = 1'b0;
               if (req_op == iedq_pkg::OP_POP) begin
                  if (fcount_ff != '0) begin
                     f_re     = 1'b1;
                     state_in = S_FRD;
                  end else if (tcount_ff != '0) begin
                     t_raddr  = thead_ff;
                     t_re     = 1'b1;
                     state_in = S_TRD;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = iedq_pkg::ST_NOTHING;
                  end
               end else if (req_delay_ms == '0) begin
                  rsp_valid_in = 1'b1;
                  if (fcount_ff == F_FULL) begin
                     rsp_status_in = iedq_pkg::ST_FULL;
                  end else begin
                     f_we          = 1'b1;
                     ftail_in      = (ftail_ff == F_LAST) ? '0 : ftail_ff + FAW'(1);
                     fcount_in     = fcount_ff + FCW'(1);
                     rsp_status_in = iedq_pkg::ST_ACCEPTED;
                  end
               end else if (tcount_ff == T_FULL) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = iedq_pkg::ST_FULL;
               end else if (tcount_ff == '0) begin
                  t_we          = 1'b1;
                  t_waddr       = thead_ff;
                  t_wdata       = {rel_sat, req_payload};
                  tcount_in     = TCW'(1);
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = iedq_pkg::ST_ACCEPTED;
               end else begin
                  t_re     = 1'b1;
                  pos_in   = tcount_ff;
                  state_in = S_INS;
               end
            end
         end
         S_FRD: begin
            fhead_in      = (fhead_ff == F_LAST) ? '0 : fhead_ff + FAW'(1);
            fcount_in     = fcount_ff - FCW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = iedq_pkg::ST_DELIVERED;
            rsp_event_in  = f_rdata;
            state_in      = S_IDLE;
         end
         S_TRD: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (t_rrel <= now_ff) begin
               thead_in      = (thead_ff == T_LAST) ? '0 : thead_ff + TAW'(1);
               tcount_in     = tcount_ff - TCW'(1);
               rsp_status_in = iedq_pkg::ST_DELIVERED;
               rsp_event_in  = t_rdata[WORD_BITS-1:0];
               rsp_timed_in  = 1'b1;
            end else begin
               rsp_status_in = iedq_pkg::ST_NOTHING;
            end
         end
         S_INS: begin
            t_we = 1'b1;
            if (t_rrel > rel_ff) begin
               t_wdata = t_rdata;
               pos_in  = pos_ff - TCW'(1);
               if (pos_ff == TCW'(1)) begin
                  state_in = S_FIN;
               end else begin
                  t_raddr = tidx(thead_ff, off_b[TAW-1:0]);
                  t_re    = 1'b1;
               end
            end else begin
               tcount_in     = tcount_ff + TCW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = iedq_pkg::ST_ACCEPTED;
               state_in      = S_IDLE;
            end
         end
         S_FIN: begin
            t_we          = 1'b1;
            tcount_in     = tcount_ff + TCW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = iedq_pkg::ST_ACCEPTED;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fhead_ff     <= '0;
         ftail_ff     <= '0;
         fcount_ff    <= '0;
         thead_ff     <= '0;
         tcount_ff    <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fhead_ff     <= fhead_in;
         ftail_ff     <= ftail_in;
         fcount_ff    <= fcount_in;
         thead_ff     <= thead_in;
         tcount_ff    <= tcount_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff        <= now_in;
      rel_ff        <= rel_in;
      word_ff       <= word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_event_ff  <= rsp_event_in;
      rsp_timed_ff  <= rsp_timed_in;
   end

   iedq_ram #(.WIDTH(WORD_BITS), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (ftail_ff),
      .wr_data (req_payload),
      .rd_en   (f_re),
      .rd_addr (fhead_ff),
      .rd_data (f_rdata)
   );

   iedq_ram #(.WIDTH(EW), .DEPTH(TIMED_DEPTH)) u_timed_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_en   (t_re),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_event_out  = rsp_event_ff;
   assign rsp_from_timed = rsp_timed_ff;

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fcount_ff <= F_FULL) else $error("FIFO occupancy exceeds depth");

   a_timed_bound: assert property (@(posedge clock) disable iff (reset)
      tcount_ff <= T_FULL) else $error("Timed occupancy exceeds depth");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_IDLE) else $error("Result shown while busy");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || busy)) else $error("Accepted beat was dropped");

   a_timed_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_timed_ff) |-> rsp_status_ff == iedq_pkg::ST_DELIVERED)
      else $error("Timed flag without delivery");

endmodule

// File: rtl/core/iedq_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
module iedq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
